// ===== hdl/cfir_pkg.sv =====
// shared types and constants of the complex fir filter
// no dependencies; imported by complex_fir_filter

package cfir_pkg;

    // width of the tap count configuration field
    localparam int TAP_COUNT_W = 7;

    // width of the coefficient index field of a request
    localparam int COEF_INDEX_W = 7;

    // request operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

// ===== hdl/complex_fir_filter.sv =====
// complex fir filter: coefficient store, circular delay line and one shared
// complex-by-real multiply-accumulate unit under a small sequencer
// depends on cfir_pkg

// A coefficient-load request gives no result. A sample request is taken,
// then the shared multiply-accumulate unit works through L taps, where L
// is the tap count in effect (0 counts as 1, values above MAX_TAPS count
// as MAX_TAPS), each through a registered coefficient and delay-line read;
// then its pipeline empties and the sum is rounded and saturated into the
// result register once that is free. The single read port of each memory
// feeding that one unit sets the pace. The block takes no request while a
// sample is in work. After reset a clearing pass zeroes the coefficient
// store one address after another; configuration writes are taken during
// it. Writing tap_count empties the delay line at once.

module complex_fir_filter #(
    parameter int MAX_TAPS     = 128,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [cfir_pkg::TAP_COUNT_W-1:0]    i_cfg_data,
    // input requests
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [cfir_pkg::COEF_INDEX_W-1:0]   i_coef_index,
    input  logic [COEF_WIDTH-1:0]               i_coef_value,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_im,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_out_re,
    output logic signed [SAMPLE_WIDTH-1:0]      o_out_im,
    output logic                                o_saturated
);

    import cfir_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int AW    = $clog2(MAX_TAPS);
    localparam int LW    = (AW + 1 > TAP_COUNT_W) ? AW + 1 : TAP_COUNT_W;
    localparam int PW    = SW + CW + 1;
    localparam int ACC_W = (SW + CW + 8 > 64) ? 64 : SW + CW + 8;
    localparam int HW    = ACC_W - CW;

    localparam logic [ACC_W-1:0]       RND    = ACC_W'(1) << (CW - 1);
    localparam logic signed [HW-1:0]   SAT_HI = HW'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic signed [HW-1:0]   SAT_LO = ~SAT_HI;
    localparam logic [LW-1:0]          LEN_MAX = LW'(MAX_TAPS);
    localparam logic [AW-1:0]          LAST_ADDR = AW'(MAX_TAPS - 1);

    // round to nearest, shift down and saturate; top bit flags clipping
    function automatic logic [SW:0] f_finish(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0]      u;
        logic signed [HW-1:0]  v;
        logic [SW:0]           res;
        u = acc + RND;
        v = u[ACC_W-1:CW];
        if (v > SAT_HI) begin
            res = {1'b1, SAT_HI[SW-1:0]};
        end else if (v < SAT_LO) begin
            res = {1'b1, SAT_LO[SW-1:0]};
        end else begin
            res = {1'b0, v[SW-1:0]};
        end
        return res;
    endfunction

    // memories
    logic [CW-1:0]     coef_mem [MAX_TAPS];
    logic [2*SW-1:0]   line_mem [MAX_TAPS];

    // sequencer and bookkeeping
    t_state            r_state, n_state;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_slot;
    logic [AW-1:0]     r_ptr;
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     r_fill;

    // mac pipeline
    logic [CW-1:0]           r_coef_q;
    logic [2*SW-1:0]         r_line_q;
    logic                    r_v1;
    logic                    r_ok1;
    logic signed [PW-1:0]    r_prod_re;
    logic signed [PW-1:0]    r_prod_im;
    logic                    r_v2;
    logic [ACC_W-1:0]        r_acc_re;
    logic [ACC_W-1:0]        r_acc_im;

    // result register
    logic                    r_out_valid;
    logic signed [SW-1:0]    r_out_re;
    logic signed [SW-1:0]    r_out_im;
    logic                    r_out_sat;

    // decoded controls
    logic              w_accept;
    logic              w_start;
    logic              w_load;
    logic              w_clear;
    logic              w_issue;
    logic              w_last;
    logic              w_out_load;
    logic              w_slot_ok;
    logic [LW-1:0]     w_cfg_len;
    logic [SW:0]       w_fin_re;
    logic [SW:0]       w_fin_im;
    logic signed [SW-1:0] w_x_re;
    logic signed [SW-1:0] w_x_im;

    // request decode
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_start  = w_accept && (i_operation == OP_SAMPLE);
    assign w_load   = w_accept && (i_operation == OP_LOAD) &&
                      (32'(i_coef_index) < 32'(MAX_TAPS));
    assign w_last   = (LW'(r_idx) == r_len - LW'(1));

    // a slot holds a sample once written since the line was emptied
    assign w_slot_ok = (LW'(r_slot) >= r_len - r_fill);

    // effective tap count of a configuration write
    always_comb begin
        w_cfg_len = LW'(i_cfg_data);
        if (w_cfg_len == '0) begin
            w_cfg_len = LW'(1);
        end else if (w_cfg_len > LEN_MAX) begin
            w_cfg_len = LEN_MAX;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_start) n_state = S_RUN;
            end
            S_RUN: begin
                if (w_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_clear    = 1'b0;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_CLEAR:  w_clear    = 1'b1;
            S_IDLE:   o_in_stall = 1'b0;
            S_RUN:    w_issue    = 1'b1;
            S_DRAIN:  ;
            S_FINISH: w_out_load = !r_out_valid || !i_out_stall;
            default:  ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // tap counter, read slot, write pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_slot <= '0;
            r_ptr  <= '0;
            r_len  <= LW'(1);
            r_fill <= '0;
        end else begin
            if (w_clear || w_issue) begin
                r_idx <= r_idx + AW'(1);
            end
            if (w_issue) begin
                r_slot <= (LW'(r_slot) == r_len - LW'(1)) ? '0 : r_slot + AW'(1);
            end
            if (w_start) begin
                r_idx  <= '0;
                r_slot <= r_ptr;
                r_ptr  <= (r_ptr == '0) ? AW'(r_len - LW'(1)) : r_ptr - AW'(1);
                if (r_fill != r_len) r_fill <= r_fill + LW'(1);
            end
            if (i_cfg_we) begin
                r_len  <= w_cfg_len;
                r_ptr  <= AW'(w_cfg_len - LW'(1));
                r_fill <= '0;
            end
        end
    end

    // coefficient store: clearing pass, loads, tap reads
    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            coef_mem[r_idx] <= '0;
        end else if (w_load) begin
            coef_mem[AW'(i_coef_index)] <= i_coef_value;
        end
        r_coef_q <= coef_mem[r_idx];
    end

    // delay line: sample write at the pointer, tap reads
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            line_mem[r_ptr] <= {i_sample_im, i_sample_re};
        end
        r_line_q <= line_mem[r_slot];
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
    end

    // shared complex-by-real multiply, unwritten slots read as zero
    assign w_x_re = r_ok1 ? $signed(r_line_q[SW-1:0])    : '0;
    assign w_x_im = r_ok1 ? $signed(r_line_q[2*SW-1:SW]) : '0;

    always_ff @(posedge i_clk) begin
        r_ok1     <= w_slot_ok;
        r_prod_re <= w_x_re * $signed({1'b0, r_coef_q});
        r_prod_im <= w_x_im * $signed({1'b0, r_coef_q});
    end

    // accumulate, wrapping at the accumulator width
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + ACC_W'(r_prod_re);
            r_acc_im <= r_acc_im + ACC_W'(r_prod_im);
        end
    end

    // round, shift and saturate
    assign w_fin_re = f_finish(r_acc_re);
    assign w_fin_im = f_finish(r_acc_im);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_re  <= $signed(w_fin_re[SW-1:0]);
            r_out_im  <= $signed(w_fin_im[SW-1:0]);
            r_out_sat <= w_fin_re[SW] | w_fin_im[SW];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_saturated = r_out_sat;

    // write pointer stays inside the taps in use
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_ptr) < r_len)
        else $error("write pointer outside tap range");

    // fill count never passes the tap count
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_len)
        else $error("fill count above tap count");

    // products only arrive while a sample is in work
    a_mac_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("product outside a sample pass");

    // a finished sum reaches the result register once it is free
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !(r_out_valid && i_out_stall)) |=>
            (r_out_valid && r_state == S_IDLE))
        else $error("finished sum not presented");

endmodule
